FILE: design/rce_pkg.sv
// ----------------------------------------------------------------------------
// Execute unit package
// Shared sizes, command codes, status codes and control structures.
// ----------------------------------------------------------------------------
package rce_pkg;

   localparam int unsigned CMD_W    = 5;
   localparam int unsigned RIDX_W   = 5;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned LINE_W   = 10;
   localparam int unsigned WIDX_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CORE_W   = 2;

   localparam int unsigned MEM_WORDS    = 1024;
   localparam int unsigned REGION_WORDS = 256;
   localparam int unsigned NUM_REGS     = 32;
   localparam int unsigned PROG_LINES   = 1024;

   localparam logic [CMD_W-1:0] CMD_ADD  = 5'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 5'd1;
   localparam logic [CMD_W-1:0] CMD_MUL  = 5'd2;
   localparam logic [CMD_W-1:0] CMD_DIV  = 5'd3;
   localparam logic [CMD_W-1:0] CMD_ADDI = 5'd4;
   localparam logic [CMD_W-1:0] CMD_MULI = 5'd5;
   localparam logic [CMD_W-1:0] CMD_LA   = 5'd6;
   localparam logic [CMD_W-1:0] CMD_LW   = 5'd7;
   localparam logic [CMD_W-1:0] CMD_SW   = 5'd8;
   localparam logic [CMD_W-1:0] CMD_BNE  = 5'd9;
   localparam logic [CMD_W-1:0] CMD_BEQ  = 5'd10;
   localparam logic [CMD_W-1:0] CMD_BGE  = 5'd11;
   localparam logic [CMD_W-1:0] CMD_BLE  = 5'd12;
   localparam logic [CMD_W-1:0] CMD_JAL  = 5'd13;
   localparam logic [CMD_W-1:0] CMD_JALR = 5'd14;
   localparam logic [CMD_W-1:0] CMD_J    = 5'd15;
   localparam logic [CMD_W-1:0] CMD_JR   = 5'd16;
   localparam logic [CMD_W-1:0] CMD_LI   = 5'd17;
   localparam logic [CMD_W-1:0] CMD_DATA = 5'd18;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_X0     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIV0   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_HALTED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [RIDX_W-1:0] dest_reg;
      logic [RIDX_W-1:0] src_a;
      logic [RIDX_W-1:0] src_b;
      logic [DATA_W-1:0] immediate;
      logic [LINE_W-1:0] target_line;
      logic [LINE_W-1:0] line_index;
      logic [WIDX_W-1:0] word_index;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0]   next_line;
      logic                branch_taken;
      logic                reg_written;
      logic [RIDX_W-1:0]   write_reg;
      logic [DATA_W-1:0]   write_value;
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   cycles_done;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic read_ops;
      logic mem_access;
      logic div_start;
      logic commit;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clearing;
      logic is_div;
      logic div_done;
   } stat_type;

endpackage

FILE: design/rce_if.sv
// ----------------------------------------------------------------------------
// Execute unit channels
// Valid/ready channels for requests, results and the core id register.
// ----------------------------------------------------------------------------
interface rce_req_if
   import rce_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rce_rsp_if
   import rce_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rce_csr_if
   import rce_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CORE_W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/rce_divider.sv
// ----------------------------------------------------------------------------
// Execute unit divider
// Radix-2 restoring signed divider, truncating toward zero.
// ----------------------------------------------------------------------------
module rce_divider
   import rce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);
   localparam int unsigned CNT_W = $clog2(DATA_W) + 1;

   logic [DATA_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W-1:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
      trial   = {1'b0, shifted} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         den_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff[DATA_W-1] || !trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
endmodule

FILE: design/rce_datapath.sv
// ----------------------------------------------------------------------------
// Execute unit datapath
// Register file, data memory, ALU, divider and architectural state.
// ----------------------------------------------------------------------------
module rce_datapath
   import rce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           ctl,
   output stat_type          stat,
   input  req_type           req,
   input  logic [CORE_W-1:0] core_id,
   output rsp_type           rsp
);
   localparam int unsigned MA_W = $clog2(MEM_WORDS);
   localparam int unsigned RA_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   logic [DATA_W-1:0] regs_ff [NUM_REGS];
   logic [DATA_W-1:0] mem [MEM_WORDS];
   logic [MA_W:0]     clr_ff, clr_in;

   req_type           r_ff;
   logic [DATA_W-1:0] va_ff, vb_ff, vd_ff, ld_ff, pc_ff, cnt_ff;
   logic              halt_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [RA_W-1:0]   ra, rb, rd;
   logic [DATA_W-1:0] eaddr, wq, prod, quot, result, jt, new_pc;
   logic [MA_W-1:0]   maddr, daddr;
   logic              writes, taken, jreg, err_x0, err_d0, div_done;
   logic [LINE_W-1:0] next;
   logic [DATA_W-1:0] l1;

   assign ra = RA_W'(r_ff.src_a % NUM_REGS);
   assign rb = RA_W'(r_ff.src_b % NUM_REGS);
   assign rd = RA_W'(r_ff.dest_reg % NUM_REGS);

   // Word address: signed byte address divided by four, truncated toward zero.
   assign eaddr = va_ff + r_ff.immediate;
   assign wq    = eaddr[DATA_W-1] ? (~((~eaddr + 1'b1) >> 2) + 1'b1) : (eaddr >> 2);
   assign maddr = MA_W'(wq + DATA_W'(REGION_WORDS) * DATA_W'(core_id));
   assign daddr = MA_W'(DATA_W'(r_ff.word_index % REGION_WORDS)
                        + DATA_W'(REGION_WORDS) * DATA_W'(core_id));

   rce_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (va_ff),
      .divisor  (vb_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign prod = (r_ff.cmd == CMD_MULI) ? va_ff * r_ff.immediate : va_ff * vb_ff;

   always_comb begin
      writes = 1'b0;
      taken  = 1'b0;
      jreg   = 1'b0;
      jt     = '0;
      result = '0;
      case (r_ff.cmd)
         CMD_ADD:  begin writes = 1'b1; result = va_ff + vb_ff; end
         CMD_SUB:  begin writes = 1'b1; result = va_ff - vb_ff; end
         CMD_MUL:  begin writes = 1'b1; result = prod; end
         CMD_DIV:  begin writes = 1'b1; result = quot; end
         CMD_ADDI: begin writes = 1'b1; result = va_ff + r_ff.immediate; end
         CMD_MULI: begin writes = 1'b1; result = prod; end
         CMD_LA:   begin writes = 1'b1; result = {r_ff.immediate[DATA_W-3:0], 2'b00}; end
         CMD_LW:   begin writes = 1'b1; result = ld_ff; end
         CMD_BNE:  taken = (va_ff != vb_ff);
         CMD_BEQ:  taken = (va_ff == vb_ff);
         CMD_BGE:  taken = ($signed(va_ff) >= $signed(vb_ff));
         CMD_BLE:  taken = ($signed(vb_ff) >= $signed(va_ff));
         CMD_JAL:  begin writes = 1'b1; result = pc_ff; taken = 1'b1; end
         CMD_JALR: begin writes = 1'b1; result = pc_ff; jreg = 1'b1; jt = eaddr; end
         CMD_J:    taken = 1'b1;
         CMD_JR:   begin jreg = 1'b1; jt = vd_ff; end
         CMD_LI:   begin writes = 1'b1; result = r_ff.immediate; end
         default:  ;
      endcase
   end

   assign err_x0 = writes && (rd == '0);
   assign err_d0 = (r_ff.cmd == CMD_DIV) && (vb_ff == '0);
   assign l1     = (jt >> 2) + 1'b1;

   always_comb begin
      next   = LINE_W'((DATA_W'(r_ff.line_index) + 1'b1) % PROG_LINES);
      new_pc = pc_ff + 32'd4;
      if (taken) begin
         next   = LINE_W'((DATA_W'(r_ff.target_line) + 1'b1) % PROG_LINES);
         new_pc = (DATA_W'(r_ff.target_line) + 1'b1) << 2;
      end
      if (jreg) begin
         next   = LINE_W'(l1 % PROG_LINES);
         new_pc = l1 << 2;
      end
   end

   assign clr_in = clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (ctl.capture) r_ff <= req;
      if (ctl.read_ops) begin
         va_ff <= regs_ff[RA_W'(req.src_a % NUM_REGS)];
         vb_ff <= regs_ff[RA_W'(req.src_b % NUM_REGS)];
         vd_ff <= regs_ff[RA_W'(req.dest_reg % NUM_REGS)];
      end
      if (reset) begin
         clr_ff <= '0;
      end else if (!clr_ff[MA_W]) begin
         mem[clr_ff[MA_W-1:0]] <= '0;
         clr_ff <= clr_in;
      end else if (ctl.mem_access && !halt_ff) begin
         if (r_ff.cmd == CMD_SW) mem[maddr] <= vd_ff;
         if (r_ff.cmd == CMD_DATA) mem[daddr] <= r_ff.immediate;
      end
      ld_ff <= mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
         pc_ff   <= '0;
         cnt_ff  <= '0;
         halt_ff <= 1'b0;
      end else if (ctl.commit && !halt_ff && r_ff.cmd != CMD_DATA) begin
         if (err_x0 || err_d0) begin
            halt_ff <= 1'b1;
         end else begin
            if (writes) regs_ff[rd] <= result;
            pc_ff  <= new_pc;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.next_line   = r_ff.line_index;
      rsp_in.cycles_done = cnt_ff;
      rsp_in.status      = ST_OK;
      if (halt_ff) begin
         rsp_in.status = ST_HALTED;
      end else if (r_ff.cmd == CMD_DATA) begin
         rsp_in.next_line   = LINE_W'((DATA_W'(r_ff.line_index) + 1'b1) % PROG_LINES);
         rsp_in.write_value = r_ff.immediate;
      end else if (err_x0) begin
         rsp_in.status = ST_X0;
      end else if (err_d0) begin
         rsp_in.status = ST_DIV0;
      end else begin
         rsp_in.next_line    = next;
         rsp_in.branch_taken = taken || jreg;
         rsp_in.reg_written  = writes;
         rsp_in.write_reg    = writes ? RIDX_W'(rd) : '0;
         rsp_in.write_value  = writes ? result : ((r_ff.cmd == CMD_SW) ? vd_ff : '0);
         rsp_in.cycles_done  = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) rsp_ff <= rsp_in;
   end

   assign stat.clearing = !clr_ff[MA_W];
   assign stat.is_div   = (r_ff.cmd == CMD_DIV) && !halt_ff && !err_x0 && !err_d0;
   assign stat.div_done = div_done;
   assign rsp           = rsp_ff;
endmodule

FILE: design/rce_control.sv
// ----------------------------------------------------------------------------
// Execute unit controller
// Sequences operand read, memory access, divide and result hand-off.
// ----------------------------------------------------------------------------
module rce_control
   import rce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  logic     busy_clear,
   input  stat_type stat,
   output cmd_type  ctl
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MEM  = 6'b000010,
      S_EXEC = 6'b000100,
      S_DIV  = 6'b001000,
      S_WAIT = 6'b010000,
      S_RSP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && !busy_clear;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            ctl.capture  = accept;
            ctl.read_ops = accept;
            if (accept) state_in = S_MEM;
         end
         S_MEM: begin
            ctl.mem_access = 1'b1;
            state_in       = S_EXEC;
         end
         S_EXEC: begin
            if (stat.is_div) begin
               ctl.div_start = 1'b1;
               state_in      = S_WAIT;
            end else begin
               ctl.commit   = 1'b1;
               ctl.rsp_load = 1'b1;
               state_in     = S_RSP;
            end
         end
         S_WAIT: state_in = S_DIV;
         S_DIV: begin
            if (stat.div_done) begin
               ctl.commit   = 1'b1;
               ctl.rsp_load = 1'b1;
               state_in     = S_RSP;
            end
         end
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

FILE: design/risc_core_execute_unit.sv
// ----------------------------------------------------------------------------
// Execute unit top level
// Runs one pre-decoded instruction per request on a small register core.
// The result is registered and offered after the MEM and EXEC states; a divide adds the WAIT and DIV states.
// A new request is taken only once the previous result has been taken.
// The MEM state serves the data memory access; the DIV state waits on the radix-2 divider.
// Reset clears state; a pass that clears every data memory word follows, with requests held.
// ----------------------------------------------------------------------------
module risc_core_execute_unit
   import rce_pkg::*;
(
   input logic     clock,
   input logic     reset,
   rce_req_if.sink req,
   rce_rsp_if.source rsp,
   rce_csr_if.sink csr
);
   cmd_type           ctl;
   stat_type          stat;
   logic [CORE_W-1:0] core_id_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) core_id_ff <= '0;
      else if (csr.valid) core_id_ff <= csr.payload;
   end

   rce_control u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .busy_clear (stat.clearing),
      .stat       (stat),
      .ctl        (ctl)
   );

   rce_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .stat    (stat),
      .req     (req.payload),
      .core_id (core_id_ff),
      .rsp     (rsp.payload)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.capture, ctl.div_start, ctl.rsp_load})) else $error("cmd clash");
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> rsp.valid) else $error("no result after load");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while result pending");
endmodule
